### hdl/xy_route_link_emitter_macros.svh
// Assertion macros for the XY route link emitter.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef XY_ROUTE_LINK_EMITTER_MACROS_SVH
`define XY_ROUTE_LINK_EMITTER_MACROS_SVH

// same-cycle implication
`define XRLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xrle check failed");

// next-cycle implication
`define XRLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xrle check failed");

`endif

### hdl/xrle_pkg.sv
// Shared types and constants of the XY route link emitter.
// No dependencies.
package xrle_pkg;

  localparam int CORE_W      = 8;
  localparam int LINK_W      = 10;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int MAX_RESULTS = 30;
  localparam int HOP_CNT_W   = 5;
  localparam int DIV_CNT_W   = 3;

  // register indexes on the configuration channel
  localparam logic CFG_MESH_ROWS = 1'b0;
  localparam logic CFG_MESH_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_DIV_SRC,
    ST_DIV_DST,
    ST_HOP,
    ST_ERR
  } state_t;

endpackage

### hdl/xrle_div.sv
// Restoring divider: core number by column count, one quotient bit a cycle.
// Depends on xrle_pkg.
module xrle_div #(
  parameter int MAX_COLS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [xrle_pkg::CORE_W-1:0]  dividend,
  input  logic [$clog2(MAX_COLS+1)-1:0] divisor,
  output logic                         done,
  output logic [xrle_pkg::CORE_W-1:0]  quot,
  output logic [$clog2(MAX_COLS+1)-1:0] rem
);
  import xrle_pkg::*;

  localparam int CW = $clog2(MAX_COLS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CORE_W-1:0]    quo_r, quo_nxt;
  logic [CW:0]          trial;
  logic [CW:0]          diff;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, quo_r[CORE_W-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so CW bits suffice
      rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_nxt = {quo_r[CORE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(CORE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

### hdl/xrle_link.sv
// Hop unit: next XY step and its directed link number, one multiplier.
// Depends on xrle_pkg.
module xrle_link #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cur_x,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] cur_y,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] goal_x,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] goal_y,
  input  logic [$clog2(MAX_ROWS+1)-1:0]                      rows_c,
  input  logic [$clog2(MAX_COLS+1)-1:0]                      cols_c,
  input  logic [$clog2(MAX_ROWS+1)+$clog2(MAX_COLS+1)+1:0]   horiz,
  input  logic [$clog2(MAX_ROWS+1)+$clog2(MAX_COLS+1)+1:0]   horiz2,
  input  logic [$clog2(MAX_ROWS+1)+$clog2(MAX_COLS+1)+1:0]   up_base,
  output logic [xrle_pkg::LINK_W-1:0]                        link_id,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] nxt_x,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] nxt_y,
  output logic                                               arrive
);
  import xrle_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int XW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LKW = RW + CW + 2;
  localparam int AW  = (XW > YW) ? XW : YW;
  localparam int BW  = (RW > CW) ? RW : CW;
  localparam int SW  = (LKW > LINK_W) ? LKW : LINK_W;

  logic [AW-1:0]    mul_a;
  logic [BW-1:0]    mul_b;
  logic [AW+BW-1:0] prod;
  logic [SW-1:0]    base;
  logic [AW-1:0]    offs;
  logic [SW-1:0]    sum;

  always_comb begin
    nxt_x = cur_x;
    nxt_y = cur_y;
    if (cur_x != goal_x) begin
      // along x: row offset y*(cols-1)
      mul_a = AW'(cur_y);
      mul_b = BW'(cols_c - 1'b1);
      if (goal_x > cur_x) begin
        base  = '0;
        offs  = AW'(cur_x);
        nxt_x = cur_x + 1'b1;
      end else begin
        base  = SW'(horiz);
        offs  = AW'(cur_x - 1'b1);
        nxt_x = cur_x - 1'b1;
      end
    end else begin
      // along y: column offset x*(rows-1)
      mul_a = AW'(cur_x);
      mul_b = BW'(rows_c - 1'b1);
      if (goal_y > cur_y) begin
        base  = SW'(horiz2);
        offs  = AW'(cur_y);
        nxt_y = cur_y + 1'b1;
      end else begin
        base  = SW'(up_base);
        offs  = AW'(cur_y - 1'b1);
        nxt_y = cur_y - 1'b1;
      end
    end
    prod    = mul_a * mul_b;
    sum     = base + SW'(prod) + SW'(offs);
    link_id = sum[LINK_W-1:0];
    arrive  = (nxt_x == goal_x) && (nxt_y == goal_y);
  end

endmodule

### hdl/xy_route_link_emitter.sv
// XY route link emitter: sequencer, config registers and output word.
// Depends on xrle_pkg, xrle_div, xrle_link and the assertion macro header.
//
// Use: a word on in_ carries a source core (tdata[7:0]) and a destination
// core (tdata[15:8]). The block walks the XY route, first along x then along
// y, and sends one word per hop on out_: the link number in tdata[9:0],
// tlast on the final hop, tuser set on a range-error word. Equal cores give
// no word; an out-of-range core gives one error word with link 0 and tlast.
// A route is cut after 30 hops, the 30th carrying tlast.
// The cfg_ channel writes mesh_rows (address 0) and mesh_cols (address 1);
// write only while idle. Values of 0 count as 1, above the maximum as the max.
// Sequence: an item is taken in the idle state, then setup and range check
// follow, the core numbers are divided by the column count in turn by one
// shared restoring divider, then one hop leaves per cycle while the output
// register is free. in_tready is high only in the idle state.
// The output register holds a word until taken; a stalled receiver holds
// the hop walk, and the next item may be taken while the last word waits.
// Reset (synchronous, rst_n low) sets rows and cols to 4 and the block idle.
`include "xy_route_link_emitter_macros.svh"

module xy_route_link_emitter #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [xrle_pkg::IN_TDATA_W-1:0]    in_tdata,   // src_core, dst_core
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [xrle_pkg::OUT_TDATA_W-1:0]   out_tdata,  // link_id, zero pad
  output logic                               out_tlast,  // last_link
  output logic                               out_tuser,  // range_error
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_addr,
  input  logic [xrle_pkg::CFG_W-1:0]         cfg_data
);
  import xrle_pkg::*;

  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int XW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LKW  = RW + CW + 2;
  localparam int CMPW = (LKW > CORE_W) ? LKW : CORE_W;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]     mesh_rows_r, mesh_cols_r;
  logic [RW-1:0]        rows_c;
  logic [CW-1:0]        cols_c;
  logic [CORE_W-1:0]    src_r, src_nxt, dst_r, dst_nxt;
  logic [LKW-1:0]       limit_r, limit_nxt;
  logic [LKW-1:0]       horiz_r, horiz_nxt, horiz2_r, horiz2_nxt, upb_r, upb_nxt;
  logic [XW-1:0]        cur_x_r, cur_x_nxt, goal_x_r, goal_x_nxt;
  logic [YW-1:0]        cur_y_r, cur_y_nxt, goal_y_r, goal_y_nxt;
  logic [HOP_CNT_W-1:0] hop_cnt_r, hop_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LINK_W-1:0]    out_link_r, out_link_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 in_acc, out_free, same_core, range_bad, cut_off, hop_last;
  logic [LKW-1:0]       h_calc;
  logic                 div_start, div_done;
  logic [CORE_W-1:0]    div_dividend, div_quot;
  logic [CW-1:0]        div_rem;
  logic [LINK_W-1:0]    hop_link;
  logic [XW-1:0]        hop_x;
  logic [YW-1:0]        hop_y;
  logic                 hop_arrive;

  // effective mesh size
  always_comb begin
    if (mesh_rows_r == '0) begin
      rows_c = RW'(1);
    end else if (32'(mesh_rows_r) > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(mesh_rows_r);
    end
    if (mesh_cols_r == '0) begin
      cols_c = CW'(1);
    end else if (32'(mesh_cols_r) > MAX_COLS) begin
      cols_c = CW'(MAX_COLS);
    end else begin
      cols_c = CW'(mesh_cols_r);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign same_core = (in_tdata[CORE_W-1:0] == in_tdata[2*CORE_W-1:CORE_W]);
  assign out_free  = !out_valid_r || out_tready;
  assign range_bad = (CMPW'(src_r) >= CMPW'(limit_r)) || (CMPW'(dst_r) >= CMPW'(limit_r));
  assign cut_off   = (hop_cnt_r == HOP_CNT_W'(MAX_RESULTS - 1));
  assign hop_last  = hop_arrive || cut_off;
  assign h_calc    = limit_r - LKW'(rows_c);

  assign div_start    = ((state_r == ST_CHECK) && !range_bad)
                        || ((state_r == ST_DIV_SRC) && div_done);
  assign div_dividend = (state_r == ST_CHECK) ? src_r : dst_r;

  xrle_div #(
    .MAX_COLS (MAX_COLS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cols_c),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  xrle_link #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_link (
    .cur_x   (cur_x_r),
    .cur_y   (cur_y_r),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .rows_c  (rows_c),
    .cols_c  (cols_c),
    .horiz   (horiz_r),
    .horiz2  (horiz2_r),
    .up_base (upb_r),
    .link_id (hop_link),
    .nxt_x   (hop_x),
    .nxt_y   (hop_y),
    .arrive  (hop_arrive)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc && !same_core) state_nxt = ST_SETUP;
      ST_SETUP:   state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = range_bad ? ST_ERR : ST_DIV_SRC;
      ST_DIV_SRC: if (div_done) state_nxt = ST_DIV_DST;
      ST_DIV_DST: if (div_done) state_nxt = ST_HOP;
      ST_HOP:     if (out_free && hop_last) state_nxt = ST_IDLE;
      ST_ERR:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    limit_nxt     = limit_r;
    horiz_nxt     = horiz_r;
    horiz2_nxt    = horiz2_r;
    upb_nxt       = upb_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    goal_x_nxt    = goal_x_r;
    goal_y_nxt    = goal_y_r;
    hop_cnt_nxt   = hop_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_link_nxt  = out_link_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          src_nxt = in_tdata[CORE_W-1:0];
          dst_nxt = in_tdata[2*CORE_W-1:CORE_W];
        end
      end
      ST_SETUP: begin
        limit_nxt = LKW'(rows_c) * LKW'(cols_c);
      end
      ST_CHECK: begin
        // H = rows*(cols-1), vertical group size = limit - cols
        horiz_nxt   = h_calc;
        horiz2_nxt  = {h_calc[LKW-2:0], 1'b0};
        upb_nxt     = {h_calc[LKW-2:0], 1'b0} + limit_r - LKW'(cols_c);
        hop_cnt_nxt = '0;
      end
      ST_DIV_SRC: begin
        if (div_done) begin
          cur_x_nxt = XW'(div_rem);
          cur_y_nxt = YW'(div_quot);
        end
      end
      ST_DIV_DST: begin
        if (div_done) begin
          goal_x_nxt = XW'(div_rem);
          goal_y_nxt = YW'(div_quot);
        end
      end
      ST_HOP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_link_nxt  = hop_link;
          out_last_nxt  = hop_last;
          out_err_nxt   = 1'b0;
          cur_x_nxt     = hop_x;
          cur_y_nxt     = hop_y;
          hop_cnt_nxt   = hop_cnt_r + 1'b1;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_link_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hop_cnt_r   <= '0;
      mesh_rows_r <= CFG_W'(4);
      mesh_cols_r <= CFG_W'(4);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hop_cnt_r   <= hop_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          CFG_MESH_ROWS: mesh_rows_r <= cfg_data;
          CFG_MESH_COLS: mesh_cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    limit_r    <= limit_nxt;
    horiz_r    <= horiz_nxt;
    horiz2_r   <= horiz2_nxt;
    upb_r      <= upb_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    goal_x_r   <= goal_x_nxt;
    goal_y_r   <= goal_y_nxt;
    out_link_r <= out_link_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - LINK_W){1'b0}}, out_link_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // an error word always closes its item
  `XRLE_ASSERT_IMP(a_err_is_last, out_tvalid && out_tuser, out_tlast)
  // the walk never runs past the hop limit
  `XRLE_ASSERT_IMP(a_hop_cnt_bound, state_r == ST_HOP, hop_cnt_r < HOP_CNT_W'(MAX_RESULTS))
  // while walking, the goal has not yet been reached
  `XRLE_ASSERT_IMP(a_hop_not_home, state_r == ST_HOP,
                   (cur_x_r != goal_x_r) || (cur_y_r != goal_y_r))
  // a hop taken leaves a word in the output register
  `XRLE_ASSERT_NXT(a_hop_loads_out, (state_r == ST_HOP) && out_free,
                   out_tvalid && !out_tuser)

endmodule
